// ===== sv/smd_pkg.sv =====
// ---------------------------------------------------------------------------
// smd_pkg
// Shared types, constants and helpers for the switch matrix debouncer.
// ---------------------------------------------------------------------------
package smd_pkg;

   // Matrix geometry and derived widths.
   localparam int unsigned ROWS      = 8;
   localparam int unsigned COLS      = 8;
   localparam int unsigned CELLS     = ROWS * COLS;
   localparam int unsigned IDX_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int unsigned ROW_W     = 3;
   localparam int unsigned COL_W     = 3;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned DEB_W     = 16;
   localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

   // Per-switch mode codes.
   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_ON   = 2'd1,
      MODE_DEB  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   // One stored switch entry.
   typedef struct packed {
      mode_type            mode;
      logic                pend;
      logic [TIME_W-1:0]   start;
   } entry_type;

   // Settled mode that corresponds to a sampled level.
   function automatic mode_type level_mode(input logic lvl);
      mode_type m;
      m = lvl ? MODE_ON : MODE_OFF;
      return m;
   endfunction

endpackage

// ===== sv/smd_store.sv =====
// ---------------------------------------------------------------------------
// smd_store
// Per-switch entry memory with registered read and per-entry valid bits.
// ---------------------------------------------------------------------------
module smd_store (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [smd_pkg::IDX_W-1:0] rd_idx,
   output smd_pkg::entry_type       rd_entry,
   input  logic                     wr_en,
   input  logic [smd_pkg::IDX_W-1:0] wr_idx,
   input  smd_pkg::entry_type       wr_entry
);

   smd_pkg::entry_type           mem [smd_pkg::CELLS];
   logic [smd_pkg::CELLS-1:0]    valid_ff;
   logic [smd_pkg::CELLS-1:0]    valid_in;
   smd_pkg::entry_type           rd_data_ff;
   logic                         rd_valid_ff;

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   // Valid bits mark entries that were written since reset.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   // An entry never written reads as a switch that is not yet set.
   always_comb begin
      rd_entry = rd_data_ff;
      if (!rd_valid_ff) begin
         rd_entry.mode = smd_pkg::MODE_NONE;
      end
   end

endmodule

// ===== sv/smd_update.sv =====
// ---------------------------------------------------------------------------
// smd_update
// Next-state logic for one switch sample: settle, start or resolve debounce.
// ---------------------------------------------------------------------------
module smd_update (
   input  smd_pkg::entry_type              cur,
   input  logic                            active,
   input  logic [smd_pkg::TIME_W-1:0]      now_ms,
   input  logic [smd_pkg::DEB_W-1:0]       debounce_time,
   output smd_pkg::entry_type              nxt,
   output logic                            event_res
);

   logic [smd_pkg::TIME_W-1:0] elapsed;

   // Modular elapsed time, so a wrapped clock still measures correctly.
   assign elapsed = now_ms - cur.start;

   always_comb begin
      nxt       = cur;
      event_res = 1'b0;
      case (cur.mode)
         smd_pkg::MODE_NONE: begin
            nxt.mode = smd_pkg::level_mode(active);
         end
         smd_pkg::MODE_DEB: begin
            // Once the wait is over, the sample decides the outcome.
            if (elapsed >= {{(smd_pkg::TIME_W-smd_pkg::DEB_W){1'b0}}, debounce_time}) begin
               if (cur.pend == active) begin
                  nxt.mode  = smd_pkg::level_mode(cur.pend);
                  event_res = 1'b1;
               end else begin
                  nxt.mode = smd_pkg::level_mode(~cur.pend);
               end
            end
         end
         default: begin
            // A settled switch that sees the other level starts debouncing.
            if (cur.mode != smd_pkg::level_mode(active)) begin
               nxt.mode  = smd_pkg::MODE_DEB;
               nxt.start = now_ms;
               nxt.pend  = active;
            end
         end
      endcase
   end

endmodule

// ===== sv/switch_matrix_debouncer.sv =====
// ---------------------------------------------------------------------------
// switch_matrix_debouncer
// Debounces samples of a switch matrix, one switch entry per sample.
// ---------------------------------------------------------------------------
// An accepted sample passes through the input stage and the result register to the rsp_ ports.
// Throughput: one sample per cycle unless rsp_stall holds the result; the entry memory read is registered at
// acceptance and the updated entry is written back as the result is stored.
// Reset: synchronous; every switch reads as not set, debounce time is 50 ms.
module switch_matrix_debouncer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [smd_pkg::DEB_W-1:0]       csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [smd_pkg::ROW_W-1:0]       req_row,
   input  logic [smd_pkg::COL_W-1:0]       req_col,
   input  logic                            req_active,
   input  logic [smd_pkg::TIME_W-1:0]      req_now_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_event_res,
   output logic [smd_pkg::ROW_W-1:0]       rsp_event_row,
   output logic [smd_pkg::COL_W-1:0]       rsp_event_col,
   output logic [1:0]                      rsp_switch_state
);

   logic [smd_pkg::DEB_W-1:0]   debounce_time_ff;
   logic                        s1_vld_ff;
   logic [smd_pkg::ROW_W-1:0]   s1_row_ff;
   logic [smd_pkg::COL_W-1:0]   s1_col_ff;
   logic                        s1_active_ff;
   logic [smd_pkg::TIME_W-1:0]  s1_now_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_event_ff;
   logic [smd_pkg::ROW_W-1:0]   rsp_row_ff;
   logic [smd_pkg::COL_W-1:0]   rsp_col_ff;
   logic [1:0]                  rsp_state_ff;
   logic                        fwd_vld_ff;
   logic [smd_pkg::IDX_W-1:0]   fwd_idx_ff;
   smd_pkg::entry_type          fwd_entry_ff;

   logic                        req_accept;
   logic                        advance;
   logic                        s1_in_range;
   logic [smd_pkg::IDX_W-1:0]   req_idx;
   logic [smd_pkg::IDX_W-1:0]   s1_idx;
   smd_pkg::entry_type          rd_entry;
   smd_pkg::entry_type          cur_entry;
   smd_pkg::entry_type          nxt_entry;
   logic                        upd_event;
   logic                        wr_en;

   // Handshake: stage one moves on when the result register is free or taken.
   assign advance    = s1_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_vld_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   // Flat entry index of a switch.
   assign req_idx = smd_pkg::IDX_W'(int'(req_row) * smd_pkg::COLS + int'(req_col));
   assign s1_idx  = smd_pkg::IDX_W'(int'(s1_row_ff) * smd_pkg::COLS + int'(s1_col_ff));
   assign s1_in_range = (int'(s1_row_ff) < smd_pkg::ROWS) &&
                        (int'(s1_col_ff) < smd_pkg::COLS);

   assign wr_en = advance && s1_in_range;

   // Debounce time register.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff <= smd_pkg::DEBOUNCE_RESET;
      end else if (csr_wr_en) begin
         debounce_time_ff <= csr_wr_data;
      end
   end

   smd_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_idx   (req_idx),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_idx   (s1_idx),
      .wr_entry (nxt_entry)
   );

   // The write made on the acceptance edge is not yet in the read data,
   // so the most recent write is bypassed when it hits the same switch.
   always_comb begin
      cur_entry = rd_entry;
      if (fwd_vld_ff && (fwd_idx_ff == s1_idx)) begin
         cur_entry = fwd_entry_ff;
      end
   end

   smd_update u_update (
      .cur           (cur_entry),
      .active        (s1_active_ff),
      .now_ms        (s1_now_ff),
      .debounce_time (debounce_time_ff),
      .nxt           (nxt_entry),
      .event_res     (upd_event)
   );

   // Input stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_accept) begin
         s1_vld_ff <= 1'b1;
      end else if (advance) begin
         s1_vld_ff <= 1'b0;
      end
   end

   // Input stage payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_row_ff    <= req_row;
         s1_col_ff    <= req_col;
         s1_active_ff <= req_active;
         s1_now_ff    <= req_now_ms;
      end
   end

   // Last written entry, kept for the bypass.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
      end else if (wr_en) begin
         fwd_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_idx_ff   <= s1_idx;
         fwd_entry_ff <= nxt_entry;
      end
   end

   // Result register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload; a switch outside the matrix reports not set.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_event_ff <= s1_in_range && upd_event;
         rsp_row_ff   <= s1_row_ff;
         rsp_col_ff   <= s1_col_ff;
         rsp_state_ff <= s1_in_range ? nxt_entry.mode : smd_pkg::MODE_NONE;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_event_ff;
   assign rsp_event_row    = rsp_row_ff;
   assign rsp_event_col    = rsp_col_ff;
   assign rsp_switch_state = rsp_state_ff;

endmodule
